>>> rtl/core/vll_pkg.sv
// ----------------------------------------------------------------------------
// vll_pkg
// Shared widths, constants and pipeline control type of the van Leer slope
// limiter core.
// ----------------------------------------------------------------------------
package vll_pkg;

	localparam int DATA_W = 32;
	localparam int CW_W   = 31;
	localparam int MAG_W  = 32;
	localparam int PROD_W = 64;
	localparam int DEN_W  = 64;
	localparam int QB     = 32;
	localparam int FRAC_SH = 17;

	localparam logic [CW_W-1:0]   CW_RESET = 31'd65536;
	localparam logic [DATA_W-1:0] SAT_POS  = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_NEG  = 32'h8000_0000;

	typedef struct packed {
		logic vld;
		logic zero;
		logic neg;
		logic over;
	} ctl_t;

endpackage

>>> rtl/core/van_leer_limited_slope_core.sv
// ----------------------------------------------------------------------------
// van_leer_limited_slope_core
// Van Leer limited slope of a four-point stencil: 2*N*D / ((N + D) * dx)
// for a positive smoothness ratio, zero otherwise, signed Q16.16, saturated.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         handshake
//  s_*      in   tdata: upper_next, upper, lower, lower_next     tvalid/tready
//                tuser: upwind_dir
//  m_*      out  tdata: slope                                    tvalid/tready
//  cfg_*    in   cell_width (31 bits, reset 1.0)                 write enable
//
//  One request per cycle unless the output stalls. Stages: difference,
//  two multiplier stages, overflow compare, 32 divider stages and the
//  output register. The 32-stage restoring divider sets the latency.
//  Reset clears all valid bits and sets cell_width to 1.0.
//  A stalled output freezes the whole pipe; the input is taken whenever the
//  output register is empty or being drained.
// ----------------------------------------------------------------------------
module van_leer_limited_slope_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [127:0]                  s_tdata,  // upper_next, upper, lower, lower_next
	input  logic                          s_tuser,  // upwind_dir
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [vll_pkg::DATA_W-1:0]    m_tdata,  // slope
	input  logic                          cfg_we,
	input  logic [vll_pkg::CW_W-1:0]      cfg_wdata
);

	localparam int DW = vll_pkg::DATA_W;
	localparam int MW = vll_pkg::MAG_W;
	localparam int PW = vll_pkg::PROD_W;
	localparam int NW = vll_pkg::DEN_W;
	localparam int QB = vll_pkg::QB;
	localparam int SH = vll_pkg::FRAC_SH;
	localparam int HI_W = PW - (QB - SH);

	logic [vll_pkg::CW_W-1:0] cell_width_q;

	logic                 adv;
	logic                 acc;
	logic signed [DW-1:0] upper_next, upper, lower, lower_next;
	logic                 upwind_dir;
	logic signed [DW:0]   d_c, n_c;
	logic [DW:0]          ad_c, an_c;

	vll_pkg::ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_dv;
	logic [MW-1:0]        an_s1, ad_s1;
	logic [PW-1:0]        prod_s2, prod_s3;
	logic [MW:0]          sum_s2;
	logic [NW-1:0]        den_s3, den_s4;
	logic [NW-1:0]        rem_s4;
	logic [QB-1:0]        dvd_s4;
	logic [QB-1:0]        quo_dv;
	logic [NW-1:0]        hi_c;
	logic                 over_c;

	logic                 m_vld_q;
	logic [DW-1:0]        slope_q;
	logic [DW-1:0]        slope_c;

	assign adv      = !m_vld_q || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	assign upper_next = s_tdata[31:0];
	assign upper      = s_tdata[63:32];
	assign lower      = s_tdata[95:64];
	assign lower_next = s_tdata[127:96];
	assign upwind_dir = s_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q <= vll_pkg::CW_RESET;
		end else if (cfg_we) begin
			cell_width_q <= cfg_wdata;
		end
	end

	assign d_c  = {upper[DW-1], upper} - {lower[DW-1], lower};
	assign n_c  = upwind_dir ? ({lower[DW-1], lower} - {lower_next[DW-1], lower_next})
	                         : ({upper_next[DW-1], upper_next} - {upper[DW-1], upper});
	assign ad_c = d_c[DW] ? -d_c : d_c;
	assign an_c = n_c[DW] ? -n_c : n_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s1.vld  <= acc;
			ctl_s1.zero <= (d_c == '0) || (n_c == '0) || (d_c[DW] != n_c[DW]);
			ctl_s1.neg  <= d_c[DW];
			ctl_s1.over <= 1'b0;
			ctl_s2      <= ctl_s1;
			ctl_s3      <= ctl_s2;
			ctl_s4      <= '{vld: ctl_s3.vld, zero: ctl_s3.zero, neg: ctl_s3.neg,
			                 over: over_c};
		end
	end

	assign hi_c   = {{(NW-HI_W){1'b0}}, prod_s3[PW-1:QB-SH]};
	assign over_c = hi_c >= den_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			an_s1   <= an_c[MW-1:0];
			ad_s1   <= ad_c[MW-1:0];
			prod_s2 <= PW'(an_s1) * PW'(ad_s1);
			sum_s2  <= {1'b0, an_s1} + {1'b0, ad_s1};
			prod_s3 <= prod_s2;
			den_s3  <= NW'(sum_s2) * NW'(cell_width_q);
			den_s4  <= den_s3;
			rem_s4  <= over_c ? '0 : hi_c;
			dvd_s4  <= {prod_s3[QB-SH-1:0], {SH{1'b0}}};
		end
	end

	vll_div_pipe u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.ctl_i  (ctl_s4),
		.rem_i  (rem_s4),
		.dvd_i  (dvd_s4),
		.den_i  (den_s4),
		.ctl_o  (ctl_dv),
		.quo_o  (quo_dv)
	);

	always_comb begin
		slope_c = '0;
		if (!ctl_dv.zero) begin
			if (ctl_dv.neg) begin
				if (ctl_dv.over || (quo_dv > vll_pkg::SAT_NEG)) begin
					slope_c = vll_pkg::SAT_NEG;
				end else begin
					slope_c = -quo_dv;
				end
			end else begin
				if (ctl_dv.over || quo_dv[QB-1]) begin
					slope_c = vll_pkg::SAT_POS;
				end else begin
					slope_c = quo_dv;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (adv) begin
			m_vld_q <= ctl_dv.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slope_q <= slope_c;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = slope_q;

	a_flat_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (s_tdata[63:32] == s_tdata[95:64])) |=> (ctl_s1.vld && ctl_s1.zero))
		else $error("flat difference not flagged as zero slope");

	a_mag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.vld && !ctl_s1.zero) |-> ((an_s1 != '0) && (ad_s1 != '0)))
		else $error("zero magnitude passed as live ratio");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(ctl_s1) && $stable(ctl_s4)))
		else $error("pipeline moved during stall");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ctl_dv.vld && ctl_dv.zero) |=> (m_tvalid && (m_tdata == '0)))
		else $error("zero-ratio request gave nonzero slope");

endmodule

>>> rtl/core/vll_div_pipe.sv
// ----------------------------------------------------------------------------
// vll_div_pipe
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The remainder entering stage zero is below the divisor unless the request
// is flagged as overflowed.
// ----------------------------------------------------------------------------
module vll_div_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  vll_pkg::ctl_t                 ctl_i,
	input  logic [vll_pkg::DEN_W-1:0]     rem_i,
	input  logic [vll_pkg::QB-1:0]        dvd_i,
	input  logic [vll_pkg::DEN_W-1:0]     den_i,
	output vll_pkg::ctl_t                 ctl_o,
	output logic [vll_pkg::QB-1:0]        quo_o
);

	localparam int QB = vll_pkg::QB;
	localparam int DW = vll_pkg::DEN_W;

	vll_pkg::ctl_t     ctl_s [QB];
	logic [DW-1:0]     rem_s [QB];
	logic [QB-1:0]     dvd_s [QB];
	logic [DW-1:0]     den_s [QB];
	logic [QB-1:0]     quo_s [QB];

	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_stage
			vll_pkg::ctl_t ctl_p;
			logic [DW-1:0] rem_p;
			logic [QB-1:0] dvd_p;
			logic [DW-1:0] den_p;
			logic [QB-1:0] quo_p;
			logic [DW:0]   trial;
			logic [DW:0]   diff;
			logic          ge;

			if (k == 0) begin : g_first
				assign ctl_p = ctl_i;
				assign rem_p = rem_i;
				assign dvd_p = dvd_i;
				assign den_p = den_i;
				assign quo_p = '0;
			end else begin : g_next
				assign ctl_p = ctl_s[k-1];
				assign rem_p = rem_s[k-1];
				assign dvd_p = dvd_s[k-1];
				assign den_p = den_s[k-1];
				assign quo_p = quo_s[k-1];
			end

			assign trial = {rem_p, dvd_p[QB-1]};
			assign diff  = trial - {1'b0, den_p};
			assign ge    = trial >= {1'b0, den_p};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ctl_s[k] <= '0;
				end else if (en) begin
					ctl_s[k] <= ctl_p;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
					dvd_s[k] <= {dvd_p[QB-2:0], 1'b0};
					den_s[k] <= den_p;
					quo_s[k] <= {quo_p[QB-2:0], ge};
				end
			end
		end
	endgenerate

	assign ctl_o = ctl_s[QB-1];
	assign quo_o = quo_s[QB-1];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s[QB-1].vld && !ctl_s[QB-1].zero && !ctl_s[QB-1].over)
			|-> (rem_s[QB-1] < den_s[QB-1]))
		else $error("divider remainder not below divisor");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(ctl_o))
		else $error("divider output control moved during stall");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ctl_i.vld) |=> ctl_s[0].vld)
		else $error("divider dropped an entering request");

endmodule

>>> sim/van_leer_limited_slope_core_tb.sv
// ----------------------------------------------------------------------------
// van_leer_limited_slope_core_tb
// Self-checking bench for the van Leer slope limiter core. Stencil requests
// go in on the slave stream and slopes come back on the master stream. Each
// slope is checked in order against a bit-exact software predictor. Cell width
// settings (reset, unit, extremes, zero, random) and flow control mixes vary.
// ----------------------------------------------------------------------------
module van_leer_limited_slope_core_tb;

	localparam int CYCLE_LIMIT    = 600000;
	localparam int PIPE_LATENCY   = 37;
	localparam int PHASE_REQUESTS = 250;
	localparam int NUM_PHASES     = 8;
	localparam int MAX_REPORTS    = 100;
	localparam int DW             = vll_pkg::DATA_W;
	localparam int CWW            = vll_pkg::CW_W;

	typedef struct packed {
		logic [DW-1:0] upper_next;
		logic [DW-1:0] upper;
		logic [DW-1:0] lower;
		logic [DW-1:0] lower_next;
		logic          upwind_dir;
	} stencil_t;

	class slope_scoreboard;
		logic [CWW-1:0] dx;
		logic [DW-1:0]  pending_slopes[$];
		int             requests;
		int             checked;
		int             errors;
		int             zero_slopes;
		int             sat_slopes;

		function new();
			dx = vll_pkg::CW_RESET;
		endfunction

		function logic signed [33:0] widen(logic [DW-1:0] v);
			return {{2{v[DW-1]}}, v};
		endfunction

		function logic [DW-1:0] limited_slope(stencil_t st);
			logic signed [33:0] diff;
			logic signed [33:0] upw;
			logic [127:0]       mag_d;
			logic [127:0]       mag_n;
			logic [127:0]       prod;
			logic [127:0]       den;
			logic [127:0]       quo;
			diff = widen(st.upper) - widen(st.lower);
			if (st.upwind_dir)
				upw = widen(st.lower) - widen(st.lower_next);
			else
				upw = widen(st.upper_next) - widen(st.upper);
			if (diff == 0 || upw == 0 || diff[33] != upw[33])
				return '0;
			mag_d = 128'(diff[33] ? -diff : diff);
			mag_n = 128'(upw[33] ? -upw : upw);
			if (dx == 0) begin
				quo = '1;
			end else begin
				prod = (mag_n * mag_d) << vll_pkg::FRAC_SH;
				den  = (mag_n + mag_d) * 128'(dx);
				quo  = prod / den;
			end
			if (diff[33]) begin
				if (quo > 128'h8000_0000)
					return vll_pkg::SAT_NEG;
				return -quo[DW-1:0];
			end
			if (quo > 128'h7FFF_FFFF)
				return vll_pkg::SAT_POS;
			return quo[DW-1:0];
		endfunction

		function void note_request(stencil_t st);
			logic [DW-1:0] want;
			want = limited_slope(st);
			pending_slopes.push_back(want);
			requests++;
			if (want == '0)
				zero_slopes++;
			if (want == vll_pkg::SAT_POS || want == vll_pkg::SAT_NEG)
				sat_slopes++;
		endfunction

		function void check_slope(logic [DW-1:0] got);
			logic [DW-1:0] want;
			if (pending_slopes.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: slope %h with no request pending", $time, got);
				return;
			end
			want = pending_slopes.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: slope mismatch expected %h actual %h", $time, want, got);
			end
		endfunction

		function int pending();
			return pending_slopes.size();
		endfunction
	endclass

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           s_tvalid  = 1'b0;
	logic           s_tready;
	logic [127:0]   s_tdata   = '0;  // upper_next, upper, lower, lower_next
	logic           s_tuser   = 1'b0;  // upwind_dir
	logic           m_tvalid;
	logic           m_tready  = 1'b0;
	logic [DW-1:0]  m_tdata;  // slope
	logic           cfg_we    = 1'b0;
	logic [CWW-1:0] cfg_wdata = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;
	int widths_used    = 1;

	slope_scoreboard sb = new();

	van_leer_limited_slope_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_slope(m_tdata);
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	function automatic stencil_t make_stencil(logic [DW-1:0] un, logic [DW-1:0] up,
			logic [DW-1:0] lo, logic [DW-1:0] ln, logic dir);
		stencil_t st;
		st.upper_next = un;
		st.upper      = up;
		st.lower      = lo;
		st.lower_next = ln;
		st.upwind_dir = dir;
		return st;
	endfunction

	function automatic logic [DW-1:0] edge_value();
		case ($urandom_range(0, 4))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3:       return 32'h0000_0001;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic stencil_t random_stencil();
		stencil_t      st;
		int            kind;
		logic [DW-1:0] dd;
		logic [DW-1:0] nn;
		kind = $urandom_range(0, 9);
		st = make_stencil($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
		if (kind >= 2 && kind <= 7) begin
			dd = $urandom >> $urandom_range(0, 31);
			nn = $urandom >> $urandom_range(0, 31);
			if ($urandom_range(0, 1))
				dd = -dd;
			if ($urandom_range(0, 9) < 7) begin
				if (dd[DW-1])
					nn = -nn;
			end else if ($urandom_range(0, 1)) begin
				nn = -nn;
			end
			st.upper = st.lower + dd;
			if (st.upwind_dir)
				st.lower_next = st.lower - nn;
			else
				st.upper_next = st.upper + nn;
		end else if (kind == 8) begin
			st.upper = st.lower;
		end else if (kind == 9) begin
			st = make_stencil(edge_value(), edge_value(), edge_value(), edge_value(),
				1'($urandom_range(0, 1)));
		end
		return st;
	endfunction

	task automatic send_request(stencil_t st);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {st.lower_next, st.lower, st.upper, st.upper_next};
		s_tuser  <= st.upwind_dir;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(st);
	endtask

	task automatic drain_slopes();
		s_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	task automatic write_cell_width(logic [CWW-1:0] width);
		cfg_we    <= 1'b1;
		cfg_wdata <= width;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.dx = width;
		widths_used++;
	endtask

	initial begin
		logic [CWW-1:0] phase_width[NUM_PHASES];
		int             mode;

		phase_width[0] = 31'd1;
		phase_width[1] = 31'h7FFF_FFFF;
		phase_width[2] = 31'd0;
		phase_width[3] = vll_pkg::CW_RESET;
		phase_width[4] = 31'd32768;
		phase_width[5] = 31'($urandom_range(1, 32'h7FFF_FFFF));
		phase_width[6] = 31'($urandom_range(1, 32'h0010_0000));
		phase_width[7] = 31'd3;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed stencils at the reset cell width of 1.0
		send_request(make_stencil(32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
		send_request(make_stencil(32'h0005_0000, 32'h0003_0000, 32'h0003_0000, 32'h0001_0000, 1'b1));
		send_request(make_stencil(32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1'b1));
		send_request(make_stencil(32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 1'b1));
		send_request(make_stencil(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0, 1'b0));
		send_request(make_stencil(32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0, 1'b1));
		send_request(make_stencil(32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0, 1'b0));
		send_request(make_stencil(32'h0, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 1'b1));
		send_request(make_stencil(32'hFFFE_0000, 32'hFFFF_0000, 32'h0, 32'h5, 1'b0));
		send_request(make_stencil(32'hFFFF_FFFF, 32'h0, 32'h1, 32'h3, 1'b1));
		send_request(make_stencil(32'h3, 32'h2, 32'h1, 32'h0, 1'b0));
		send_request(make_stencil(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b1));
		send_request(make_stencil(32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b1));
		send_request(make_stencil(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1));
		send_request(make_stencil(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
		send_request(make_stencil(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		send_request(make_stencil(32'h7FFF_FFFF, 32'h0000_0001, 32'h0, 32'h8000_0000, 1'b1));
		send_request(make_stencil(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0));

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_slopes();
			write_cell_width(phase_width[p]);
			mode = p % 4;
			send_idle_pct  = (mode == 1) ? 85 : (mode == 3) ? 24 : 0;
			recv_stall_pct = (mode == 2) ? 85 : (mode == 3) ? 24 : 0;
			for (int i = 0; i < PHASE_REQUESTS; i++) begin
				// hold off until the pipe is empty
				if (i == PHASE_REQUESTS / 2)
					drain_slopes();
				send_request(random_stencil());
			end
		end

		drain_slopes();
		repeat (PIPE_LATENCY + 8) @(posedge clk);

		$display("Checked %0d slopes from %0d requests over %0d cell widths and four flow mixes",
			sb.checked, sb.requests, widths_used);
		$display("Zero slopes %0d, saturated slopes %0d, errors %0d",
			sb.zero_slopes, sb.sat_slopes, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
